[rtl/client_id_table_broadcast_assert.svh]
// assertion macros for the client id table block
`ifndef CLIENT_ID_TABLE_BROADCAST_ASSERT_SVH
`define CLIENT_ID_TABLE_BROADCAST_ASSERT_SVH

// general property, clocked on clk, off while arst_n is low
`define CIDTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// a stalled transaction keeps the given signal
`define CIDTB_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

[rtl/cidtb_pkg.sv]
package cidtb_pkg;

	localparam int MAX_CLIENTS = 32;
	localparam int ID_W = $clog2(MAX_CLIENTS);
	localparam int KEY_W = 23;
	localparam int SID_W = 5;
	localparam int CMD_W = 2;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_JOIN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LEAVE = 2'd1;

	typedef enum logic [1:0] {
		KIND_REPLY,
		KIND_FORWARD,
		KIND_UNKNOWN,
		KIND_FULL
	} kind_t;

	typedef struct packed {
		logic                   is_leave;
		logic                   single;
		kind_t                  kind;
		logic [KEY_W-1:0]       key;
		logic [ID_W-1:0]        id;
		logic [MAX_CLIENTS-1:0] rem;
	} qent_t;

	function automatic logic [ID_W-1:0] lowest_idx(input logic [MAX_CLIENTS-1:0] v);
		logic [ID_W-1:0] idx;
		idx = '0;
		for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = ID_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

[rtl/cidtb_front.sv]
module cidtb_front import cidtb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] command,
	input  logic [KEY_W-1:0] client_key,
	output logic             q_valid,
	input  logic             q_ready,
	output qent_t            q_data,
	input  logic             pop_leave,
	input  logic [ID_W-1:0]  rd_idx,
	output logic [KEY_W-1:0] rd_key
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_LOOK,
		F_DECIDE
	} fstate_t;

	fstate_t                state_q;
	logic [MAX_CLIENTS-1:0] used_q;
	logic [QCNT_W-1:0]      pend_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [KEY_W-1:0]       key_q;
	logic [MAX_CLIENTS-1:0] match_q;
	logic [KEY_W-1:0]       slot_key_q [MAX_CLIENTS];

	logic [MAX_CLIENTS-1:0] match_c;
	logic [ID_W-1:0]        hit_idx;
	logic [ID_W-1:0]        free_idx;
	logic [MAX_CLIENTS-1:0] hit_bit;
	logic [MAX_CLIENTS-1:0] free_bit;
	logic                   hit;
	logic                   has_free;
	logic                   claim;
	logic                   stall;
	logic                   push;
	logic [MAX_CLIENTS-1:0] used_nxt;

	assign in_ready = (state_q == F_IDLE);
	assign rd_key   = slot_key_q[rd_idx];

	always_comb begin
		for (int i = 0; i < MAX_CLIENTS; i++) begin
			match_c[i] = used_q[i] && (slot_key_q[i] == key_q);
		end
	end

	assign hit      = |match_q;
	assign has_free = ~&used_q;
	assign hit_idx  = lowest_idx(match_q);
	assign free_idx = lowest_idx(~used_q);
	assign hit_bit  = MAX_CLIENTS'(1) << hit_idx;
	assign free_bit = MAX_CLIENTS'(1) << free_idx;

	always_comb begin
		q_data          = '0;
		q_data.key      = key_q;
		q_data.kind     = KIND_UNKNOWN;
		q_data.single   = 1'b1;
		claim           = 1'b0;
		used_nxt        = used_q;
		case (cmd_q)
			CMD_JOIN: begin
				if (hit) begin
					q_data.kind = KIND_REPLY;
					q_data.id   = hit_idx;
					q_data.rem  = used_q & ~hit_bit;
				end else if (!has_free) begin
					q_data.kind = KIND_FULL;
				end else begin
					claim       = 1'b1;
					q_data.kind = KIND_REPLY;
					q_data.id   = free_idx;
					q_data.rem  = used_q;
					used_nxt    = used_q | free_bit;
				end
			end
			CMD_LEAVE: begin
				if (hit) begin
					q_data.single   = 1'b0;
					q_data.is_leave = 1'b1;
					q_data.id       = hit_idx;
					q_data.rem      = used_q & ~hit_bit;
					used_nxt        = used_q & ~hit_bit;
				end
			end
			default: begin
				if (hit) begin
					q_data.single = 1'b0;
					q_data.id     = hit_idx;
					q_data.rem    = used_q & ~hit_bit;
				end
			end
		endcase
	end

	// a freed slot is not handed out again while a leave is still queued
	assign stall   = claim && (pend_q != '0);
	assign q_valid = (state_q == F_DECIDE) && !stall;
	assign push    = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			used_q  <= '0;
			pend_q  <= '0;
		end else begin
			pend_q <= pend_q + QCNT_W'(push && q_data.is_leave) - QCNT_W'(pop_leave);
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_LOOK;
					end
				end
				F_LOOK: begin
					state_q <= F_DECIDE;
				end
				F_DECIDE: begin
					if (push) begin
						used_q  <= used_nxt;
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			key_q <= client_key;
		end
		if (state_q == F_LOOK) begin
			match_q <= match_c;
		end
		if (push && claim) begin
			slot_key_q[free_idx] <= key_q;
		end
	end

endmodule

[rtl/cidtb_queue.sv]
module cidtb_queue import cidtb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  qent_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output qent_t rd_data
);

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              wr;
	logic              rd;

	assign wr_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			cnt_q <= cnt_q + QCNT_W'(wr) - QCNT_W'(rd);
			if (wr) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

[rtl/cidtb_back.sv]
module cidtb_back import cidtb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  qent_t            q_data,
	output logic             pop_leave,
	output logic [ID_W-1:0]  rd_idx,
	input  logic [KEY_W-1:0] rd_key,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [KEY_W-1:0] dest_key,
	output logic [SID_W-1:0] sender_id,
	output logic             last
);

	logic                   cur_valid_q;
	logic                   single_q;
	logic [MAX_CLIENTS-1:0] rem_q;
	kind_t                  kind_q;
	logic [KEY_W-1:0]       key_q;
	logic [ID_W-1:0]        id_q;
	logic                   ovalid_q;
	kind_t                  okind_q;
	logic [KEY_W-1:0]       odest_q;
	logic [SID_W-1:0]       oid_q;
	logic                   olast_q;

	logic [ID_W-1:0]        idx_c;
	logic [MAX_CLIENTS-1:0] rest_c;
	logic                   done_c;
	logic                   out_free;
	logic                   emit;

	assign idx_c    = lowest_idx(rem_q);
	assign rest_c   = rem_q & ~(MAX_CLIENTS'(1) << idx_c);
	assign done_c   = !cur_valid_q || (!single_q && (rem_q == '0));
	assign out_free = !ovalid_q || out_ready;
	assign emit     = cur_valid_q && !done_c && out_free;

	assign q_ready   = done_c;
	assign pop_leave = q_valid && done_c && q_data.is_leave;
	assign rd_idx    = idx_c;

	assign out_valid = ovalid_q;
	assign kind      = okind_q;
	assign dest_key  = odest_q;
	assign sender_id = oid_q;
	assign last      = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			single_q    <= 1'b0;
			rem_q       <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (done_c) begin
				cur_valid_q <= q_valid;
				if (q_valid) begin
					single_q <= q_data.single;
					rem_q    <= q_data.rem;
				end
			end else if (emit) begin
				if (single_q) begin
					single_q <= 1'b0;
				end else begin
					rem_q <= rest_c;
				end
			end
			if (out_free) begin
				ovalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_c && q_valid) begin
			kind_q <= q_data.kind;
			key_q  <= q_data.key;
			id_q   <= q_data.id;
		end
		if (emit) begin
			okind_q <= single_q ? kind_q : KIND_FORWARD;
			odest_q <= single_q ? key_q : rd_key;
			oid_q   <= SID_W'(id_q);
			olast_q <= single_q ? (rem_q == '0) : (rest_c == '0);
		end
	end

endmodule

[rtl/client_id_table_broadcast.sv]
// client id table with fan-out of notices
// input channel: in_valid/in_ready with command and client_key; one transaction
//   per join, leave or message
// output channel: out_valid/out_ready with kind, dest_key, sender_id and last;
//   each input transaction yields zero to MAX_CLIENTS results, last marks the final one
// the front end takes one input transaction at a time: capture, a parallel
//   key compare over all slots, then allocate/free and push into a 2-entry queue
// the back end pops the queue and emits one result per cycle while the output register
//   is free, walking the member mask from the lowest slot, after loading each queue entry
// the first result passes the front end states, the queue and the back end entry
//   registers to the output register; a new entry is loaded once the last is done
// a join that claims a new slot waits in the front end while a leave is still queued
// reset empties the table (every slot free), the queue and the output register;
//   no clearing pass
// when the receiver stalls, the output register holds its result, the back end
//   waits, the queue fills and in_ready stays low while the front end cannot push
module client_id_table_broadcast import cidtb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] command,
	input  logic [KEY_W-1:0] client_key,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [KEY_W-1:0] dest_key,
	output logic [SID_W-1:0] sender_id,
	output logic             last
);

	logic             fq_valid;
	logic             fq_ready;
	qent_t            fq_data;
	logic             qb_valid;
	logic             qb_ready;
	qent_t            qb_data;
	logic             pop_leave;
	logic [ID_W-1:0]  rd_idx;
	logic [KEY_W-1:0] rd_key;

	cidtb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.client_key (client_key),
		.q_valid    (fq_valid),
		.q_ready    (fq_ready),
		.q_data     (fq_data),
		.pop_leave  (pop_leave),
		.rd_idx     (rd_idx),
		.rd_key     (rd_key)
	);

	cidtb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_data),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_data)
	);

	cidtb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_data    (qb_data),
		.pop_leave (pop_leave),
		.rd_idx    (rd_idx),
		.rd_key    (rd_key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.dest_key  (dest_key),
		.sender_id (sender_id),
		.last      (last)
	);

endmodule

[rtl/cidtb_checker.sv]
`include "client_id_table_broadcast_assert.svh"

module cidtb_checker import cidtb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [CMD_W-1:0] command,
	input logic [KEY_W-1:0] client_key,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       kind,
	input logic [KEY_W-1:0] dest_key,
	input logic [SID_W-1:0] sender_id,
	input logic             last
);

	logic err_kind;

	assign err_kind = (kind == KIND_UNKNOWN) || (kind == KIND_FULL);

	// stalled input transaction keeps its payload
	`CIDTB_ASSERT_HOLD(a_in_cmd_hold, in_valid, in_ready, command, "stalled command changed")
	`CIDTB_ASSERT_HOLD(a_in_key_hold, in_valid, in_ready, client_key, "stalled key changed")

	// stalled result keeps its destination
	`CIDTB_ASSERT_HOLD(a_out_hold, out_valid, out_ready, dest_key, "stalled result changed")

	// error and full results stand alone
	`CIDTB_ASSERT(a_err_last, (out_valid && err_kind) |-> last, "error result without last")

	// error and full results carry id zero
	`CIDTB_ASSERT(a_err_id, (out_valid && err_kind) |-> (sender_id == '0), "error result id")

endmodule

bind client_id_table_broadcast cidtb_checker u_chk (.*);
